[rtl/hka_pkg.sv]
// Shared constants, types and hash helper functions for the avalanche key search.
`default_nettype none

package hka_pkg;

	// Hash width after folding and the fixed field widths.
	localparam int HASH_BITS = 16;
	localparam int IN_BITS   = 16;
	localparam int KEY_W     = 16;
	localparam int DATA_W    = 16;
	localparam int PROD_W    = 32;
	localparam int SCORE_W   = 8;
	localparam int TOTAL_W   = 24;

	// Derived widths for the popcount, the per-flip term and the raw score sum.
	localparam int HALF      = HASH_BITS / 2;
	localparam int PC_W      = $clog2(HASH_BITS + 1);
	localparam int TERM_W    = $clog2(HALF + 1);
	localparam int SUM_W     = SCORE_W + 2;

	// Saturation limits and the largest score the hash width allows.
	localparam int SCORE_MAX   = 255;
	localparam int SCORE_BOUND = (IN_BITS * HALF > SCORE_MAX) ? SCORE_MAX : IN_BITS * HALF;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [DATA_W-1:0]  data_t;
	typedef logic [PROD_W-1:0]  prod_t;
	typedef logic [SCORE_W-1:0] score_t;
	typedef logic [TOTAL_W-1:0] total_t;
	typedef logic [IN_BITS-1:0][TERM_W-1:0] terms_t;

	// Control that travels with an item down the pipeline.
	typedef struct packed {
		logic vld;
		logic last;
		key_t key;
	} ctl_t;

	// Fold the bits above the hash width onto the low bits and keep the hash width.
	function automatic logic [HASH_BITS-1:0] fold_hash(input prod_t p);
		logic [PROD_W-1:0] x;
		x = p ^ (p >> HASH_BITS);
		return x[HASH_BITS-1:0];
	endfunction

	// Count the ones of a hash difference.
	function automatic logic [PC_W-1:0] ones(input logic [HASH_BITS-1:0] x);
		logic [PC_W-1:0] c;
		c = '0;
		for (int i = 0; i < HASH_BITS; i++) begin
			c = c + PC_W'(x[i]);
		end
		return c;
	endfunction

	// Distance of a popcount from half the hash width.
	function automatic logic [TERM_W-1:0] half_dist(input logic [PC_W-1:0] pc);
		logic [PC_W-1:0] d;
		if (pc >= PC_W'(HALF)) begin
			d = pc - PC_W'(HALF);
		end else begin
			d = PC_W'(HALF) - pc;
		end
		return d[TERM_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/hka_mul.sv]
// Stage two: the key times value product, registered with the item's control.
`default_nettype none

module hka_mul (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire hka_pkg::ctl_t   ctl_s1,
	input  wire hka_pkg::data_t  data_s1,
	output hka_pkg::ctl_t        ctl_s2,
	output hka_pkg::data_t       data_s2,
	output hka_pkg::prod_t       prod_s2
);
	import hka_pkg::*;

	// Control of the stage; reset clears the valid bit and the rest of the control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Payload: one 16 by 16 product per item.
	always_ff @(posedge clk) begin
		if (en) begin
			data_s2     <= data_s1;
			prod_s2     <= PROD_W'(ctl_s1.key) * PROD_W'(data_s1);
		end
	end

endmodule

`default_nettype wire

[rtl/hka_terms.sv]
// Stage three: the sixteen bit-flip hashes and their distance terms.
`default_nettype none

module hka_terms (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire hka_pkg::ctl_t   ctl_s2,
	input  wire hka_pkg::data_t  data_s2,
	input  wire hka_pkg::prod_t  prod_s2,
	output hka_pkg::ctl_t        ctl_s3,
	output hka_pkg::terms_t      terms_s3
);
	import hka_pkg::*;

	logic [HASH_BITS-1:0] base_hash;
	terms_t               terms;

	// Flipping input bit i moves the product by the key shifted left by i,
	// up when the bit was clear and down when it was set.
	always_comb begin
		base_hash = fold_hash(prod_s2);
		for (int i = 0; i < IN_BITS; i++) begin
			prod_t sh;
			prod_t flip;
			sh = PROD_W'(ctl_s2.key) << i;
			if (data_s2[i]) begin
				flip = prod_s2 - sh;
			end else begin
				flip = prod_s2 + sh;
			end
			terms[i] = half_dist(ones(base_hash ^ fold_hash(flip)));
		end
	end

	// Control of the stage; reset clears the valid bit and the rest of the control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			terms_s3    <= terms;
		end
	end

endmodule

`default_nettype wire

[rtl/hka_track.sv]
// Final stage: score sum, per-key running total, best-key tracking and result register.
`default_nettype none

module hka_track (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire hka_pkg::ctl_t    ctl_s3,
	input  wire hka_pkg::terms_t  terms_s3,
	output logic                  vld_q,
	output hka_pkg::score_t       score_q,
	output hka_pkg::total_t       total_q,
	output logic                  nb_q,
	output hka_pkg::key_t         best_key_q,
	output hka_pkg::total_t       best_sum_q
);
	import hka_pkg::*;

	logic [SUM_W-1:0]   raw_sum;
	score_t             score;
	logic [TOTAL_W:0]   total_wide;
	total_t             total;
	logic               better;
	total_t             run_q;

	// Sum the sixteen terms, saturate the score, then add it to the running total.
	always_comb begin
		raw_sum = '0;
		for (int i = 0; i < IN_BITS; i++) begin
			raw_sum = raw_sum + SUM_W'(terms_s3[i]);
		end
		if (raw_sum > SUM_W'(SCORE_MAX)) begin
			score = SCORE_W'(SCORE_MAX);
		end else begin
			score = raw_sum[SCORE_W-1:0];
		end
		total_wide = {1'b0, run_q} + (TOTAL_W + 1)'(score);
		total      = total_wide[TOTAL_W] ? TOTAL_MAX : total_wide[TOTAL_W-1:0];
		better     = ctl_s3.last && (total < best_sum_q);
	end

	// Key state and the valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= 1'b0;
			run_q      <= '0;
			best_key_q <= '0;
			best_sum_q <= TOTAL_MAX;
		end else if (en) begin
			vld_q <= ctl_s3.vld;
			if (ctl_s3.vld) begin
				run_q <= ctl_s3.last ? '0 : total;
				if (better) begin
					best_key_q <= ctl_s3.key;
					best_sum_q <= total;
				end
			end
		end
	end

	// Per-item result fields.
	always_ff @(posedge clk) begin
		if (en) begin
			score_q <= score;
			total_q <= total;
			nb_q    <= better;
		end
	end

endmodule

`default_nettype wire

[rtl/hash16_avalanche_key_search_top.sv]
// Top level of the multiplicative hash avalanche key search.
// Each item passes through the input, product, terms and result registers in order.
// Throughput: one item per cycle while not held; every stage takes a new item each cycle.
// The whole pipeline holds while a result waits on m_tready.
// Reset clears the stage valid bits, the running sum and best key, and sets
// the best total to all ones (no key closed yet).
`default_nettype none

module hash16_avalanche_key_search_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // key_value [15:0], data_value [31:16]
	input  wire logic        s_tlast,   // last_of_key
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// input_score [7:0], key_total [31:8], new_best [32], best_key [48:33],
	// best_total [72:49], zero fill [79:73]
	output logic [79:0]      m_tdata
);
	import hka_pkg::*;

	logic    adv;
	ctl_t    ctl_s1;
	data_t   data_s1;
	ctl_t    ctl_s2;
	data_t   data_s2;
	prod_t   prod_s2;
	ctl_t    ctl_s3;
	terms_t  terms_s3;
	score_t  score;
	total_t  total;
	logic    nb;
	key_t    best_key;
	total_t  best_total;

	// The pipeline moves whenever the result register is empty or being taken.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Input register: control with reset, data value without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.vld  <= s_tvalid;
			ctl_s1.key  <= s_tdata[KEY_W-1:0];
			ctl_s1.last <= s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1     <= s_tdata[KEY_W +: DATA_W];
		end
	end

	hka_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.ctl_s1  (ctl_s1),
		.data_s1 (data_s1),
		.ctl_s2  (ctl_s2),
		.data_s2 (data_s2),
		.prod_s2 (prod_s2)
	);

	hka_terms u_terms (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.ctl_s2   (ctl_s2),
		.data_s2  (data_s2),
		.prod_s2  (prod_s2),
		.ctl_s3   (ctl_s3),
		.terms_s3 (terms_s3)
	);

	hka_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.ctl_s3     (ctl_s3),
		.terms_s3   (terms_s3),
		.vld_q      (m_tvalid),
		.score_q    (score),
		.total_q    (total),
		.nb_q       (nb),
		.best_key_q (best_key),
		.best_sum_q (best_total)
	);

	// Pack the result fields, lowest field first.
	assign m_tdata = {7'b0, best_total, best_key, nb, total, score};

`ifndef SYNTHESIS
	// The best total can only go down.
	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		##1 best_total <= $past(best_total))
		else $error("best total increased");

	// A new best carries the closing total as the best total.
	a_new_best_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && nb |-> best_total == total)
		else $error("new best does not match key total");

	// No score exceeds the bound set by the hash width.
	a_score_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> score <= SCORE_W'(SCORE_BOUND))
		else $error("score out of range");
`endif

endmodule

`default_nettype wire
